[rtl/core/lupmi_pkg.sv]
// ----------------------------------------------------------------------------
// lupmi_pkg: shared types and constants of the LU pivot matrix inverse
// Q16.16 constants, datapath command and status types, saturation helper.
// ----------------------------------------------------------------------------
`default_nettype none

package lupmi_pkg;

	localparam int DATA_W        = 32;
	localparam int ORDER_W       = 3;
	localparam int DEF_MAX_ORDER = 4;
	localparam int ACC_W         = 40;
	localparam int DIV_STEPS     = 48;
	localparam int DIV_CNT_W     = 6;
	localparam int FRAC_W        = 16;
	localparam int ORDER_RESET   = 4;

	localparam logic signed [DATA_W-1:0] Q_ONE  = 32'sh0001_0000;
	localparam logic signed [DATA_W-1:0] Q_ZERO = 32'sh0000_0000;
	localparam logic signed [DATA_W-1:0] Q_MAX  = 32'sh7FFF_FFFF;
	localparam logic signed [DATA_W-1:0] Q_MIN  = 32'sh8000_0000;

	// arithmetic operation of one datapath command
	typedef enum logic [2:0] {
		OP_NONE = 3'd0,
		OP_CLR  = 3'd1,
		OP_MUL  = 3'd2,
		OP_ACC  = 3'd3,
		OP_SUB  = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		MUL_LU = 2'd0,
		MUL_LW = 2'd1,
		MUL_UW = 2'd2
	} mul_sel_t;

	typedef enum logic [1:0] {
		BASE_A    = 2'd0,
		BASE_W    = 2'd1,
		BASE_ONE  = 2'd2,
		BASE_ZERO = 2'd3
	} base_sel_t;

	typedef enum logic {
		DIV_FACT = 1'b0,
		DIV_BACK = 1'b1
	} div_sel_t;

	typedef enum logic { W_RES = 1'b0, W_QUO = 1'b1 } w_src_t;
	typedef enum logic { U_RES = 1'b0, U_PIV = 1'b1 } u_src_t;
	typedef enum logic { L_ONE = 1'b0, L_QUO = 1'b1 } l_src_t;
	typedef enum logic { M_LOAD = 1'b0, M_QUO = 1'b1 } m_src_t;

	// controller to datapath
	typedef struct packed {
		op_t       op;
		mul_sel_t  mul_sel;
		base_sel_t base_sel;
		logic      piv_clr;
		logic      piv_upd;
		logic      div_start;
		div_sel_t  div_sel;
		logic      w_we;
		w_src_t    w_src;
		logic      u_we;
		u_src_t    u_src;
		logic      l_we;
		l_src_t    l_src;
		logic      m_we;
		m_src_t    m_src;
		logic      out_ld;
		logic      out_sing;
		logic      out_last;
		logic [1:0] out_row;
		logic [1:0] out_col;
		logic      sat_clr;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic better;
		logic best_zero;
		logic div_done;
	} stat_t;

	typedef struct packed {
		logic                     ovf;
		logic signed [DATA_W-1:0] val;
	} clamp_t;

	// clamp a 64-bit value to the signed 32-bit range
	function automatic clamp_t clamp32(input logic signed [63:0] v);
		clamp_t r;
		if (v > 64'sh0000_0000_7FFF_FFFF) begin
			r.ovf = 1'b1;
			r.val = Q_MAX;
		end else if (v < 64'shFFFF_FFFF_8000_0000) begin
			r.ovf = 1'b1;
			r.val = Q_MIN;
		end else begin
			r.ovf = 1'b0;
			r.val = v[DATA_W-1:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

[rtl/core/lupmi_div.sv]
// ----------------------------------------------------------------------------
// lupmi_div: serial Q16.16 divider
// Restoring divide, one quotient bit per cycle, truncation toward zero,
// saturated to the signed 32-bit range. A zero divisor gives zero.
// ----------------------------------------------------------------------------
`default_nettype none

module lupmi_div (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             start,
	input  wire logic signed [lupmi_pkg::DATA_W-1:0] num,
	input  wire logic signed [lupmi_pkg::DATA_W-1:0] den,
	output logic signed [lupmi_pkg::DATA_W-1:0]      quo,
	output logic                                     ovf,
	output logic                                     done
);
	import lupmi_pkg::*;

	localparam int SH_W = DATA_W + FRAC_W;

	logic                 busy_q;
	logic                 fin_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DATA_W-1:0]    rem_q;
	logic [SH_W-1:0]      sh_q;
	logic [DATA_W-1:0]    dm_q;
	logic                 neg_q;
	logic                 zero_q;
	logic signed [DATA_W-1:0] quo_q;
	logic                 ovf_q;

	logic [DATA_W:0]      trial;
	logic                 fits;
	logic [DATA_W-1:0]    num_mag;
	logic [DATA_W-1:0]    den_mag;

	assign num_mag = num[DATA_W-1] ? DATA_W'(-num) : DATA_W'(num);
	assign den_mag = den[DATA_W-1] ? DATA_W'(-den) : DATA_W'(den);
	assign trial   = {rem_q, sh_q[SH_W-1]};
	assign fits    = trial >= {1'b0, dm_q};

	// control: busy, step count, finish and done pulses
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			fin_q  <= 1'b0;
			done_q <= fin_q;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(DIV_STEPS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end
			end
		end
	end

	// shift-subtract datapath and final sign and clamp
	always_ff @(posedge clk) begin
		if (start) begin
			dm_q   <= den_mag;
			sh_q   <= {num_mag, {FRAC_W{1'b0}}};
			rem_q  <= '0;
			neg_q  <= num[DATA_W-1] ^ den[DATA_W-1];
			zero_q <= (den == Q_ZERO);
		end else if (busy_q) begin
			rem_q <= fits ? DATA_W'(trial - {1'b0, dm_q}) : trial[DATA_W-1:0];
			sh_q  <= {sh_q[SH_W-2:0], fits};
		end
		if (fin_q) begin
			if (zero_q) begin
				quo_q <= Q_ZERO;
				ovf_q <= 1'b0;
			end else if (!neg_q) begin
				if (sh_q > SH_W'(48'h0000_7FFF_FFFF)) begin
					quo_q <= Q_MAX;
					ovf_q <= 1'b1;
				end else begin
					quo_q <= sh_q[DATA_W-1:0];
					ovf_q <= 1'b0;
				end
			end else begin
				if (sh_q > SH_W'(48'h0000_8000_0000)) begin
					quo_q <= Q_MIN;
					ovf_q <= 1'b1;
				end else begin
					quo_q <= DATA_W'(-sh_q);
					ovf_q <= 1'b0;
				end
			end
		end
	end

	assign quo  = quo_q;
	assign ovf  = ovf_q;
	assign done = done_q;

endmodule

`default_nettype wire

[rtl/core/lupmi_dp.sv]
// ----------------------------------------------------------------------------
// lupmi_dp: datapath of the LU pivot matrix inverse
// Matrix, L, U and work stores, Q16.16 multiply-accumulate with clamps,
// pivot tracking, the serial divider and the result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module lupmi_dp #(
	parameter int MAX_ORDER = lupmi_pkg::DEF_MAX_ORDER,
	parameter int IDX_W     = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1,
	parameter int ADR_W     = 2 * IDX_W
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire lupmi_pkg::cmd_t                  cmd,
	output lupmi_pkg::stat_t                      stat,
	input  wire logic [ADR_W-1:0]                 m_addr,
	input  wire logic [ADR_W-1:0]                 l_addr,
	input  wire logic [ADR_W-1:0]                 u_addr,
	input  wire logic [IDX_W-1:0]                 w_addr,
	input  wire logic signed [lupmi_pkg::DATA_W-1:0] element_value,
	output logic signed [lupmi_pkg::DATA_W-1:0]      inverse_value,
	output logic [1:0]                            row_index,
	output logic [1:0]                            column_index,
	output logic                                  singular,
	output logic                                  saturated,
	output logic                                  last
);
	import lupmi_pkg::*;

	localparam int DEPTH = 1 << ADR_W;

	logic signed [DATA_W-1:0] m_mem [DEPTH];
	logic signed [DATA_W-1:0] l_mem [DEPTH];
	logic signed [DATA_W-1:0] u_mem [DEPTH];
	logic signed [DATA_W-1:0] w_mem [MAX_ORDER];

	logic signed [DATA_W-1:0] m_rd, l_rd, u_rd, w_rd;
	logic signed [DATA_W-1:0] mul_a, mul_b, base;
	logic signed [63:0]       prod_s1;
	logic signed [63:0]       prod_scaled;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [DATA_W-1:0] res_q;
	logic [DATA_W:0]          best_q;
	logic                     have_q;
	logic signed [DATA_W-1:0] pval_q;
	logic                     sat_q;
	logic [DATA_W:0]          res_mag;
	clamp_t                   prod_c;
	clamp_t                   sub_c;
	logic signed [DATA_W-1:0] div_num, div_den, div_quo;
	logic                     div_ovf, div_done;

	assign m_rd = m_mem[m_addr];
	assign l_rd = l_mem[l_addr];
	assign u_rd = u_mem[u_addr];
	assign w_rd = w_mem[w_addr];

	// operand selection
	always_comb begin
		mul_a = (cmd.mul_sel == MUL_UW) ? u_rd : l_rd;
		mul_b = (cmd.mul_sel == MUL_LU) ? u_rd : w_rd;
		unique case (cmd.base_sel)
			BASE_A:    base = m_rd;
			BASE_W:    base = w_rd;
			BASE_ONE:  base = Q_ONE;
			BASE_ZERO: base = Q_ZERO;
			default:   base = Q_ZERO;
		endcase
	end

	// product scaled by 2^-16 toward zero, then clamped
	assign prod_scaled = (prod_s1 + (prod_s1[63] ? 64'sd65535 : 64'sd0)) >>> FRAC_W;
	assign prod_c      = clamp32(prod_scaled);
	assign sub_c       = clamp32(64'(base) - 64'(acc_q));
	assign res_mag     = res_q[DATA_W-1] ? (DATA_W+1)'(-{res_q[DATA_W-1], res_q})
	                                     : {1'b0, res_q};

	assign div_num = (cmd.div_sel == DIV_FACT) ? w_rd : res_q;
	assign div_den = (cmd.div_sel == DIV_FACT) ? pval_q : u_rd;

	lupmi_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (div_num),
		.den    (div_den),
		.quo    (div_quo),
		.ovf    (div_ovf),
		.done   (div_done)
	);

	assign stat.better    = !have_q || (res_mag > best_q);
	assign stat.best_zero = (best_q == '0);
	assign stat.div_done  = div_done;

	// control flags: pivot found, saturation seen
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q <= 1'b0;
			sat_q  <= 1'b0;
		end else begin
			if (cmd.piv_clr) begin
				have_q <= 1'b0;
			end else if (cmd.piv_upd) begin
				have_q <= 1'b1;
			end
			if (cmd.sat_clr) begin
				sat_q <= 1'b0;
			end else if ((cmd.op == OP_ACC && prod_c.ovf) || (cmd.op == OP_SUB && sub_c.ovf)
			             || (div_done && div_ovf)) begin
				sat_q <= 1'b1;
			end
		end
	end

	// arithmetic registers
	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_NONE: ;
			OP_CLR:  acc_q <= '0;
			OP_MUL:  prod_s1 <= 64'(mul_a) * 64'(mul_b);
			OP_ACC:  acc_q <= acc_q + ACC_W'(prod_c.val);
			OP_SUB:  res_q <= sub_c.val;
			default: ;
		endcase
		if (cmd.piv_upd && stat.better) begin
			best_q <= res_mag;
			pval_q <= res_q;
		end
	end

	// store writes
	always_ff @(posedge clk) begin
		if (cmd.m_we) begin
			m_mem[m_addr] <= (cmd.m_src == M_LOAD) ? element_value : div_quo;
		end
		if (cmd.l_we) begin
			l_mem[l_addr] <= (cmd.l_src == L_ONE) ? Q_ONE : div_quo;
		end
		if (cmd.u_we) begin
			u_mem[u_addr] <= (cmd.u_src == U_RES) ? res_q : pval_q;
		end
		if (cmd.w_we) begin
			w_mem[w_addr] <= (cmd.w_src == W_RES) ? res_q : div_quo;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.out_ld) begin
			inverse_value <= cmd.out_sing ? Q_ZERO : m_rd;
			row_index     <= cmd.out_row;
			column_index  <= cmd.out_col;
			singular      <= cmd.out_sing;
			saturated     <= sat_q;
			last          <= cmd.out_last;
		end
	end

endmodule

`default_nettype wire

[rtl/core/lupmi_ctrl.sv]
// ----------------------------------------------------------------------------
// lupmi_ctrl: sequencer of the LU pivot matrix inverse
// Loads the matrix, runs the pivot search, U rows and L columns per column,
// then forward and back substitution per identity column, then emits the inverse or one singular result.
// ----------------------------------------------------------------------------
`default_nettype none

module lupmi_ctrl #(
	parameter int MAX_ORDER = lupmi_pkg::DEF_MAX_ORDER,
	parameter int IDX_W     = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1,
	parameter int ADR_W     = 2 * IDX_W,
	parameter int CNT_W     = $clog2(MAX_ORDER + 1)
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_write_en,
	input  wire logic [lupmi_pkg::ORDER_W-1:0] cfg_write_data,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	input  wire lupmi_pkg::stat_t              stat,
	output lupmi_pkg::cmd_t                    cmd,
	output logic [ADR_W-1:0]                   m_addr,
	output logic [ADR_W-1:0]                   l_addr,
	output logic [ADR_W-1:0]                   u_addr,
	output logic [IDX_W-1:0]                   w_addr
);
	import lupmi_pkg::*;

	typedef enum logic [29:0] {
		S_LOAD     = 30'd1 << 0,
		S_PS_START = 30'd1 << 1,
		S_PS_ROW   = 30'd1 << 2,
		S_PS_MUL   = 30'd1 << 3,
		S_PS_ACC   = 30'd1 << 4,
		S_PS_SUB   = 30'd1 << 5,
		S_PS_CMP   = 30'd1 << 6,
		S_PS_CHK   = 30'd1 << 7,
		S_UR_ROW   = 30'd1 << 8,
		S_UR_MUL   = 30'd1 << 9,
		S_UR_ACC   = 30'd1 << 10,
		S_UR_SUB   = 30'd1 << 11,
		S_UR_WR    = 30'd1 << 12,
		S_LC_ONE   = 30'd1 << 13,
		S_LC_ROW   = 30'd1 << 14,
		S_LC_WAIT  = 30'd1 << 15,
		S_FW_ROW   = 30'd1 << 16,
		S_FW_MUL   = 30'd1 << 17,
		S_FW_ACC   = 30'd1 << 18,
		S_FW_SUB   = 30'd1 << 19,
		S_FW_WR    = 30'd1 << 20,
		S_BK_ROW   = 30'd1 << 21,
		S_BK_MUL   = 30'd1 << 22,
		S_BK_ACC   = 30'd1 << 23,
		S_BK_SUB   = 30'd1 << 24,
		S_BK_DIV   = 30'd1 << 25,
		S_BK_WAIT  = 30'd1 << 26,
		S_EMIT     = 30'd1 << 27,
		S_SING     = 30'd1 << 28,
		S_OUT      = 30'd1 << 29
	} state_t;

	state_t             state_q;
	logic [ORDER_W-1:0] order_q;
	logic [CNT_W-1:0]   i_q, j_q, k_q, col_q, piv_q, r_q, c_q;
	logic               last_q;
	logic [IDX_W-1:0]   perm_q [MAX_ORDER];

	logic [CNT_W-1:0]   n, n_m1;
	logic [IDX_W-1:0]   ii, jj, kk, cc, rr, ci;
	logic [IDX_W-1:0]   p_i, p_j;
	logic               accept, load_done, emit_last;

	function automatic logic [ADR_W-1:0] adr(input logic [IDX_W-1:0] row,
	                                         input logic [IDX_W-1:0] col);
		return {row, col};
	endfunction

	// order in use: zero acts as one, above the maximum acts as the maximum
	always_comb begin
		if (order_q == '0) begin
			n = CNT_W'(1);
		end else if (32'(order_q) > MAX_ORDER) begin
			n = CNT_W'(MAX_ORDER);
		end else begin
			n = CNT_W'(order_q);
		end
	end

	assign n_m1      = CNT_W'(n - 1'b1);
	assign ii        = i_q[IDX_W-1:0];
	assign jj        = j_q[IDX_W-1:0];
	assign kk        = k_q[IDX_W-1:0];
	assign cc        = c_q[IDX_W-1:0];
	assign rr        = r_q[IDX_W-1:0];
	assign ci        = col_q[IDX_W-1:0];
	assign p_i       = perm_q[ii];
	assign p_j       = perm_q[jj];
	assign in_stall  = (state_q != S_LOAD) || cfg_write_en;
	assign out_valid = (state_q == S_OUT);
	assign accept    = in_valid && !in_stall;
	assign load_done = accept && (r_q == n_m1) && (c_q == n_m1);
	assign emit_last = (r_q == n_m1) && (c_q == n_m1);

	// sequencer state and loop counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
			order_q <= ORDER_W'(ORDER_RESET);
			i_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
			col_q   <= '0;
			piv_q   <= '0;
			r_q     <= '0;
			c_q     <= '0;
			last_q  <= 1'b0;
		end else begin
			unique case (state_q)
				S_LOAD: begin
					if (cfg_write_en) begin
						order_q <= cfg_write_data;
						r_q     <= '0;
						c_q     <= '0;
					end else if (accept) begin
						if (c_q == n_m1) begin
							c_q <= '0;
							if (r_q == n_m1) begin
								r_q     <= '0;
								i_q     <= '0;
								state_q <= S_PS_START;
							end else begin
								r_q <= CNT_W'(r_q + 1'b1);
							end
						end else begin
							c_q <= CNT_W'(c_q + 1'b1);
						end
					end
				end
				S_PS_START: begin
					j_q     <= i_q;
					state_q <= S_PS_ROW;
				end
				S_PS_ROW: begin
					k_q     <= '0;
					state_q <= (i_q != '0) ? S_PS_MUL : S_PS_SUB;
				end
				S_PS_MUL: state_q <= S_PS_ACC;
				S_PS_ACC: begin
					k_q     <= CNT_W'(k_q + 1'b1);
					state_q <= ((k_q + 1'b1) < i_q) ? S_PS_MUL : S_PS_SUB;
				end
				S_PS_SUB: state_q <= S_PS_CMP;
				S_PS_CMP: begin
					if (stat.better) begin
						piv_q <= j_q;
					end
					if ((j_q + 1'b1) < n) begin
						j_q     <= CNT_W'(j_q + 1'b1);
						state_q <= S_PS_ROW;
					end else begin
						state_q <= S_PS_CHK;
					end
				end
				S_PS_CHK: begin
					if (stat.best_zero) begin
						state_q <= S_SING;
					end else begin
						j_q     <= CNT_W'(i_q + 1'b1);
						state_q <= S_UR_ROW;
					end
				end
				S_UR_ROW: begin
					k_q <= '0;
					if (j_q >= n) begin
						state_q <= S_LC_ONE;
					end else begin
						state_q <= (i_q != '0) ? S_UR_MUL : S_UR_SUB;
					end
				end
				S_UR_MUL: state_q <= S_UR_ACC;
				S_UR_ACC: begin
					k_q     <= CNT_W'(k_q + 1'b1);
					state_q <= ((k_q + 1'b1) < i_q) ? S_UR_MUL : S_UR_SUB;
				end
				S_UR_SUB: state_q <= S_UR_WR;
				S_UR_WR: begin
					j_q     <= CNT_W'(j_q + 1'b1);
					state_q <= S_UR_ROW;
				end
				S_LC_ONE: begin
					j_q     <= CNT_W'(i_q + 1'b1);
					state_q <= S_LC_ROW;
				end
				S_LC_ROW: begin
					if (j_q >= n) begin
						if ((i_q + 1'b1) < n) begin
							i_q     <= CNT_W'(i_q + 1'b1);
							state_q <= S_PS_START;
						end else begin
							i_q     <= '0;
							col_q   <= '0;
							state_q <= S_FW_ROW;
						end
					end else begin
						state_q <= S_LC_WAIT;
					end
				end
				S_LC_WAIT: begin
					if (stat.div_done) begin
						j_q     <= CNT_W'(j_q + 1'b1);
						state_q <= S_LC_ROW;
					end
				end
				S_FW_ROW: begin
					j_q <= '0;
					if (i_q >= n) begin
						i_q     <= n_m1;
						state_q <= S_BK_ROW;
					end else begin
						state_q <= (i_q != '0) ? S_FW_MUL : S_FW_SUB;
					end
				end
				S_FW_MUL: state_q <= S_FW_ACC;
				S_FW_ACC: begin
					j_q     <= CNT_W'(j_q + 1'b1);
					state_q <= ((j_q + 1'b1) < i_q) ? S_FW_MUL : S_FW_SUB;
				end
				S_FW_SUB: state_q <= S_FW_WR;
				S_FW_WR: begin
					i_q     <= CNT_W'(i_q + 1'b1);
					state_q <= S_FW_ROW;
				end
				S_BK_ROW: begin
					j_q     <= CNT_W'(i_q + 1'b1);
					state_q <= ((i_q + 1'b1) < n) ? S_BK_MUL : S_BK_SUB;
				end
				S_BK_MUL: state_q <= S_BK_ACC;
				S_BK_ACC: begin
					j_q     <= CNT_W'(j_q + 1'b1);
					state_q <= ((j_q + 1'b1) < n) ? S_BK_MUL : S_BK_SUB;
				end
				S_BK_SUB: state_q <= S_BK_DIV;
				S_BK_DIV: state_q <= S_BK_WAIT;
				S_BK_WAIT: begin
					if (stat.div_done) begin
						if (i_q == '0) begin
							if ((col_q + 1'b1) < n) begin
								col_q   <= CNT_W'(col_q + 1'b1);
								state_q <= S_FW_ROW;
							end else begin
								r_q     <= '0;
								c_q     <= '0;
								state_q <= S_EMIT;
							end
						end else begin
							i_q     <= CNT_W'(i_q - 1'b1);
							state_q <= S_BK_ROW;
						end
					end
				end
				S_EMIT: begin
					last_q  <= emit_last;
					state_q <= S_OUT;
				end
				S_SING: begin
					last_q  <= 1'b1;
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (!out_stall) begin
						if (last_q) begin
							r_q     <= '0;
							c_q     <= '0;
							state_q <= S_LOAD;
						end else begin
							if (c_q == n_m1) begin
								c_q <= '0;
								r_q <= CNT_W'(r_q + 1'b1);
							end else begin
								c_q <= CNT_W'(c_q + 1'b1);
							end
							state_q <= S_EMIT;
						end
					end
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end

	// row permutation: identity at load end, swapped when the pivot moves
	always_ff @(posedge clk) begin
		if (state_q == S_LOAD && load_done) begin
			for (int x = 0; x < MAX_ORDER; x++) begin
				perm_q[x] <= IDX_W'(x);
			end
		end else if (state_q == S_PS_CHK && !stat.best_zero && piv_q != i_q) begin
			perm_q[ii]                 <= perm_q[piv_q[IDX_W-1:0]];
			perm_q[piv_q[IDX_W-1:0]]   <= perm_q[ii];
		end
	end

	// datapath commands and store addresses
	always_comb begin
		cmd    = '0;
		m_addr = adr(rr, cc);
		l_addr = adr(p_i, ii);
		u_addr = adr(ii, ii);
		w_addr = p_j;
		unique case (state_q)
			S_LOAD: begin
				cmd.m_we    = accept;
				cmd.m_src   = M_LOAD;
				cmd.sat_clr = cfg_write_en;
			end
			S_PS_START: cmd.piv_clr = 1'b1;
			S_PS_ROW:   cmd.op = OP_CLR;
			S_PS_MUL: begin
				cmd.op      = OP_MUL;
				cmd.mul_sel = MUL_LU;
				l_addr      = adr(p_j, kk);
				u_addr      = adr(kk, ii);
			end
			S_PS_ACC:   cmd.op = OP_ACC;
			S_PS_SUB: begin
				cmd.op       = OP_SUB;
				cmd.base_sel = BASE_A;
				m_addr       = adr(p_j, ii);
			end
			S_PS_CMP: begin
				cmd.piv_upd = 1'b1;
				cmd.w_we    = 1'b1;
				cmd.w_src   = W_RES;
				w_addr      = p_j;
			end
			S_PS_CHK: begin
				cmd.u_we  = !stat.best_zero;
				cmd.u_src = U_PIV;
				u_addr    = adr(ii, ii);
			end
			S_UR_ROW:   cmd.op = OP_CLR;
			S_UR_MUL: begin
				cmd.op      = OP_MUL;
				cmd.mul_sel = MUL_LU;
				l_addr      = adr(p_i, kk);
				u_addr      = adr(kk, jj);
			end
			S_UR_ACC:   cmd.op = OP_ACC;
			S_UR_SUB: begin
				cmd.op       = OP_SUB;
				cmd.base_sel = BASE_A;
				m_addr       = adr(p_i, jj);
			end
			S_UR_WR: begin
				cmd.u_we  = 1'b1;
				cmd.u_src = U_RES;
				u_addr    = adr(ii, jj);
			end
			S_LC_ONE: begin
				cmd.l_we  = 1'b1;
				cmd.l_src = L_ONE;
				l_addr    = adr(p_i, ii);
			end
			S_LC_ROW: begin
				cmd.div_start = (j_q < n);
				cmd.div_sel   = DIV_FACT;
				w_addr        = p_j;
			end
			S_LC_WAIT: begin
				cmd.l_we  = stat.div_done;
				cmd.l_src = L_QUO;
				l_addr    = adr(p_j, ii);
			end
			S_FW_ROW:   cmd.op = OP_CLR;
			S_FW_MUL: begin
				cmd.op      = OP_MUL;
				cmd.mul_sel = MUL_LW;
				l_addr      = adr(p_i, jj);
				w_addr      = jj;
			end
			S_FW_ACC:   cmd.op = OP_ACC;
			S_FW_SUB: begin
				cmd.op       = OP_SUB;
				cmd.base_sel = (p_i == ci) ? BASE_ONE : BASE_ZERO;
			end
			S_FW_WR: begin
				cmd.w_we  = 1'b1;
				cmd.w_src = W_RES;
				w_addr    = ii;
			end
			S_BK_ROW:   cmd.op = OP_CLR;
			S_BK_MUL: begin
				cmd.op      = OP_MUL;
				cmd.mul_sel = MUL_UW;
				u_addr      = adr(ii, jj);
				w_addr      = jj;
			end
			S_BK_ACC:   cmd.op = OP_ACC;
			S_BK_SUB: begin
				cmd.op       = OP_SUB;
				cmd.base_sel = BASE_W;
				w_addr       = ii;
			end
			S_BK_DIV: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DIV_BACK;
				u_addr        = adr(ii, ii);
			end
			S_BK_WAIT: begin
				cmd.w_we  = stat.div_done;
				cmd.w_src = W_QUO;
				w_addr    = ii;
				cmd.m_we  = stat.div_done;
				cmd.m_src = M_QUO;
				m_addr    = adr(ii, ci);
			end
			S_EMIT: begin
				cmd.out_ld   = 1'b1;
				cmd.out_last = emit_last;
				cmd.out_row  = 2'(r_q);
				cmd.out_col  = 2'(c_q);
				m_addr       = adr(rr, cc);
			end
			S_SING: begin
				cmd.out_ld   = 1'b1;
				cmd.out_sing = 1'b1;
				cmd.out_last = 1'b1;
			end
			S_OUT:      cmd.sat_clr = !out_stall && last_q;
			default: ;
		endcase
	end

endmodule

`default_nettype wire

[rtl/core/lu_pivot_matrix_inverse_top.sv]
// ----------------------------------------------------------------------------
// lu_pivot_matrix_inverse_top: Q16.16 matrix inverse by pivoted LU
// Loads an order-n matrix row-major, factors P*A = L*U, solves per identity
// column and returns the inverse row-major, or one singular result.
// ----------------------------------------------------------------------------
//
//  channel  signals                                   transaction
//  -------  ----------------------------------------  ----------------------
//  config   cfg_write_en, cfg_write_data              order write, no wait
//  input    in_valid, in_stall, element_value         one matrix element
//  output   out_valid, out_stall, inverse_value, ...  one inverse element
//
//  One element is taken per cycle while loading, unless an order write stalls
//  the input; the last element of a matrix starts the solve. At order four
//  the work is set by the 48-step serial divider (22 divisions) and the
//  multiply and accumulate loop; each result is loaded, then held until taken.
//  Input stalls from the last load until the final result is taken.
//  Reset is asynchronous; the order returns to four and loading restarts.
// ----------------------------------------------------------------------------
`default_nettype none

module lu_pivot_matrix_inverse_top #(
	parameter int MAX_ORDER = lupmi_pkg::DEF_MAX_ORDER
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_write_en,
	input  wire logic [lupmi_pkg::ORDER_W-1:0]       cfg_write_data,
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire logic signed [lupmi_pkg::DATA_W-1:0] element_value,
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output logic signed [lupmi_pkg::DATA_W-1:0]      inverse_value,
	output logic [1:0]                               row_index,
	output logic [1:0]                               column_index,
	output logic                                     singular,
	output logic                                     saturated,
	output logic                                     last
);
	import lupmi_pkg::*;

	localparam int IDX_W = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
	localparam int ADR_W = 2 * IDX_W;
	localparam int CNT_W = $clog2(MAX_ORDER + 1);

	cmd_t             cmd;
	stat_t            stat;
	logic [ADR_W-1:0] m_addr, l_addr, u_addr;
	logic [IDX_W-1:0] w_addr;

	lupmi_ctrl #(
		.MAX_ORDER (MAX_ORDER),
		.IDX_W     (IDX_W),
		.ADR_W     (ADR_W),
		.CNT_W     (CNT_W)
	) u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write_en   (cfg_write_en),
		.cfg_write_data (cfg_write_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.stat           (stat),
		.cmd            (cmd),
		.m_addr         (m_addr),
		.l_addr         (l_addr),
		.u_addr         (u_addr),
		.w_addr         (w_addr)
	);

	lupmi_dp #(
		.MAX_ORDER (MAX_ORDER),
		.IDX_W     (IDX_W),
		.ADR_W     (ADR_W)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.m_addr        (m_addr),
		.l_addr        (l_addr),
		.u_addr        (u_addr),
		.w_addr        (w_addr),
		.element_value (element_value),
		.inverse_value (inverse_value),
		.row_index     (row_index),
		.column_index  (column_index),
		.singular      (singular),
		.saturated     (saturated),
		.last          (last)
	);

	// no element is taken while a result is pending
	a_no_load_during_output: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input taken while a result is pending");

	// a singular result is a single, final, zero-valued transaction
	a_singular_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && singular) |-> (last && inverse_value == Q_ZERO))
		else $error("singular result not final or not zero");

	// after the final result the block returns to loading
	a_last_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && last) |=> (!out_valid && !in_stall) || cfg_write_en)
		else $error("block did not return to loading after final result");

	// a singular result always reports position zero
	a_singular_index: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && singular) |-> (row_index == 2'd0 && column_index == 2'd0))
		else $error("singular result with nonzero position");

endmodule

`default_nettype wire
